[hdl/egcd_pkg.sv]
package egcd_pkg;

   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_FIN   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

[hdl/extended_gcd.sv]
// Extended Euclid: gcd of two unsigned operands plus Bezout coefficients.
// Input: drive req_operand_a/req_operand_b and pulse start while busy is
// low; the beat is taken at that edge and busy rises on the next cycle.
// Output: one beat per request, held on the rsp_ ports for exactly one
// cycle with rsp_valid high; busy falls in the cycle after. The receiver
// cannot stall, so nothing waits for it.
// Each Euclid round runs a restoring division one quotient bit per cycle
// in ST_DIV; the coefficient updates are folded into the same pass
// Horner style, then applied in ST_FIN before ST_CHECK tests the remainder.
// When operand_b is zero no division runs: ST_CHECK goes straight to ST_DONE.
// One request at a time; the next is taken from the cycle after the
// result beat, so the division step sets the pace.
// Reset (synchronous, active high) returns to idle and drops any request
// in progress; no result is produced for it.
module extended_gcd (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [egcd_pkg::WIDTH-1:0]      req_operand_a,
   input  logic [egcd_pkg::WIDTH-1:0]      req_operand_b,
   output logic                            rsp_valid,
   output logic [egcd_pkg::WIDTH-1:0]      rsp_gcd_value,
   output logic signed [egcd_pkg::WIDTH:0] rsp_coef_a,
   output logic signed [egcd_pkg::WIDTH:0] rsp_coef_b
);
   localparam int W = egcd_pkg::WIDTH;

   egcd_pkg::state_type state_ff, state_in;
   logic [egcd_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0] rp_ff, rp_in, rc_ff, rc_in, rem_ff, rem_in;
   logic [W:0]   sp_ff, sp_in, sc_ff, sc_in, tp_ff, tp_in, tc_ff, tc_in;
   logic [W:0]   xs_ff, xs_in, xt_ff, xt_in;
   logic [W:0]   rem_sh, diff;
   logic         qbit;

   assign rem_sh = {rem_ff, rp_ff[W-1]};
   assign diff   = rem_sh - {1'b0, rc_ff};
   assign qbit   = ~diff[W];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rp_in = rp_ff; rc_in = rc_ff; rem_in = rem_ff;
      sp_in = sp_ff; sc_in = sc_ff; tp_in = tp_ff; tc_in = tc_ff;
      xs_in = xs_ff; xt_in = xt_ff;
      case (state_ff)
         egcd_pkg::ST_IDLE: begin
            if (start) begin
               rp_in = req_operand_a;
               rc_in = req_operand_b;
               sp_in = (W+1)'(1); sc_in = '0;
               tp_in = '0;        tc_in = (W+1)'(1);
               state_in = egcd_pkg::ST_CHECK;
            end
         end
         egcd_pkg::ST_CHECK: begin
            rem_in = '0; xs_in = '0; xt_in = '0; cnt_in = '0;
            state_in = (rc_ff == '0) ? egcd_pkg::ST_DONE : egcd_pkg::ST_DIV;
         end
         egcd_pkg::ST_DIV: begin
            // dividend shifts out MSB first; X = 2X - qbit*c accumulates -q*c
            rp_in  = {rp_ff[W-2:0], 1'b0};
            rem_in = qbit ? diff[W-1:0] : rem_sh[W-1:0];
            xs_in  = {xs_ff[W-1:0], 1'b0} - (qbit ? sc_ff : '0);
            xt_in  = {xt_ff[W-1:0], 1'b0} - (qbit ? tc_ff : '0);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == egcd_pkg::LAST_STEP) state_in = egcd_pkg::ST_FIN;
         end
         egcd_pkg::ST_FIN: begin
            rp_in = rc_ff;  rc_in = rem_ff;
            sp_in = sc_ff;  sc_in = sp_ff + xs_ff;
            tp_in = tc_ff;  tc_in = tp_ff + xt_ff;
            state_in = egcd_pkg::ST_CHECK;
         end
         egcd_pkg::ST_DONE: state_in = egcd_pkg::ST_IDLE;
         default: state_in = egcd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= egcd_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      rp_ff <= rp_in; rc_ff <= rc_in; rem_ff <= rem_in;
      sp_ff <= sp_in; sc_ff <= sc_in; tp_ff <= tp_in; tc_ff <= tc_in;
      xs_ff <= xs_in; xt_ff <= xt_in;
   end

   assign busy          = (state_ff != egcd_pkg::ST_IDLE);
   assign rsp_valid     = (state_ff == egcd_pkg::ST_DONE);
   assign rsp_gcd_value = rp_ff;
   assign rsp_coef_a    = sp_ff;
   assign rsp_coef_b    = tp_ff;
endmodule

[hdl/egcd_checker.sv]
module egcd_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised after request");
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat while idle");
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat repeated");
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy held after result");
endmodule

bind extended_gcd egcd_checker u_egcd_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid)
);
